FILE: hdl/bpo_pkg.sv
package bpo_pkg;

  // Field widths of the request and result items.
  localparam int COORD_W   = 32;
  localparam int AXIS_W    = 18;
  localparam int FRAC_BITS = 16;

  // One coordinate times one axis component, and the sum of three of them.
  localparam int PROD_W = COORD_W + AXIS_W;
  localparam int SUM_W  = PROD_W + 2;

  // Projection after dropping the fraction bits, and the overlap result.
  localparam int PROJ_W = SUM_W - FRAC_BITS;
  localparam int OVL_W  = PROJ_W + 1;

  // Stream widths, padded to whole bytes.
  localparam int S_FIELDS_W = 6 * COORD_W + 3 * AXIS_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((OVL_W + 7) / 8) * 8;

  // Defaults for the top-level parameters.
  localparam int VERTICES_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [PROJ_W-1:0]  proj_t;
  typedef logic signed [OVL_W-1:0]   ovl_t;

  // Running bounds start at the opposite extremes.
  localparam proj_t PROJ_MAX = proj_t'({1'b0, {(PROJ_W-1){1'b1}}});
  localparam proj_t PROJ_MIN = proj_t'({1'b1, {(PROJ_W-1){1'b0}}});

  // Control that travels beside the data through the lane stages.
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

FILE: hdl/box_projection_overlap_core.sv
// Channel   Direction  Signals                    Content
// s_axis    in         s_tvalid s_tready s_tdata  one vertex of each box plus the axis
// m_axis    out        m_tvalid m_tready m_tdata  overlap of the two projected intervals
//
// One request is taken every cycle while s_tready is high. A result shows on m_tvalid
// once the request that closes a group of VERTICES vertices has passed the products, the
// sum and shift, the min/max stage, the two merge stages and the queue's output register.
// Reset is synchronous and active high; it empties the pipeline and the result queue
// and restarts the vertex count and the running bounds of both boxes.
// A stalled output does not stop the input: s_tready falls only when QUEUE_DEPTH
// results have been promised and not yet taken.
module box_projection_overlap_core #(
  parameter int VERTICES    = bpo_pkg::VERTICES_DEF,
  parameter int QUEUE_DEPTH = bpo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // From bit 0 up: first_x, first_y, first_z, second_x, second_y, second_z (32 bits each),
  // axis_x, axis_y, axis_z (18 bits each), two zero bits.
  input  logic [bpo_pkg::S_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // From bit 0 up: overlap (37 bits, signed Q20.16), three zero bits.
  output logic [bpo_pkg::M_DATA_W-1:0] m_tdata
);
  import bpo_pkg::*;

  localparam int VCNT_W = $clog2(VERTICES);
  localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);

  logic [VCNT_W-1:0] vertex_count;
  logic [PEND_W-1:0] pending;
  logic              in_accept;
  logic              out_accept;
  logic              in_last;
  ctl_t              in_ctl;

  coord_t first_x;
  coord_t first_y;
  coord_t first_z;
  coord_t second_x;
  coord_t second_y;
  coord_t second_z;
  axis_t  axis_x;
  axis_t  axis_y;
  axis_t  axis_z;

  logic  first_valid;
  logic  second_valid;
  proj_t first_lo;
  proj_t first_hi;
  proj_t second_lo;
  proj_t second_hi;
  logic  merged_valid;
  ovl_t  merged;
  ovl_t  overlap;

  // Unpack the request.
  assign first_x  = coord_t'(s_tdata[0*COORD_W +: COORD_W]);
  assign first_y  = coord_t'(s_tdata[1*COORD_W +: COORD_W]);
  assign first_z  = coord_t'(s_tdata[2*COORD_W +: COORD_W]);
  assign second_x = coord_t'(s_tdata[3*COORD_W +: COORD_W]);
  assign second_y = coord_t'(s_tdata[4*COORD_W +: COORD_W]);
  assign second_z = coord_t'(s_tdata[5*COORD_W +: COORD_W]);
  assign axis_x   = axis_t'(s_tdata[6*COORD_W +: AXIS_W]);
  assign axis_y   = axis_t'(s_tdata[6*COORD_W + AXIS_W +: AXIS_W]);
  assign axis_z   = axis_t'(s_tdata[6*COORD_W + 2*AXIS_W +: AXIS_W]);

  assign in_accept  = s_tvalid && s_tready;
  assign out_accept = m_tvalid && m_tready;
  assign in_last    = (vertex_count == VCNT_W'(VERTICES - 1));

  assign in_ctl.valid = in_accept;
  assign in_ctl.last  = in_last;

  // Every result that has been promised owns a queue slot, so the queue
  // can never overflow however long the output stalls.
  assign s_tready = (pending < PEND_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      pending      <= '0;
    end else begin
      if (in_accept) begin
        vertex_count <= in_last ? '0 : vertex_count + 1'b1;
      end
      if ((in_accept && in_last) && !out_accept) begin
        pending <= pending + 1'b1;
      end else if (out_accept && !(in_accept && in_last)) begin
        pending <= pending - 1'b1;
      end
    end
  end

  // One lane per box; both see the same axis and the same control.
  bpo_lane u_first (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (in_ctl),
    .x         (first_x),
    .y         (first_y),
    .z         (first_z),
    .ax        (axis_x),
    .ay        (axis_y),
    .az        (axis_z),
    .grp_valid (first_valid),
    .grp_lo    (first_lo),
    .grp_hi    (first_hi)
  );

  bpo_lane u_second (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (in_ctl),
    .x         (second_x),
    .y         (second_y),
    .z         (second_z),
    .ax        (axis_x),
    .ay        (axis_y),
    .az        (axis_z),
    .grp_valid (second_valid),
    .grp_lo    (second_lo),
    .grp_hi    (second_hi)
  );

  // The lanes run in lockstep, so their group flags always agree.
  bpo_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (first_valid && second_valid),
    .first_lo  (first_lo),
    .first_hi  (first_hi),
    .second_lo (second_lo),
    .second_hi (second_hi),
    .out_valid (merged_valid),
    .overlap   (merged)
  );

  bpo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (merged_valid),
    .wr_data  (merged),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (overlap)
  );

  assign m_tdata = M_DATA_W'($unsigned(overlap));

endmodule

FILE: hdl/bpo_lane.sv
module bpo_lane (
  input  logic            clk,
  input  logic            rst,
  input  bpo_pkg::ctl_t   in_ctl,
  input  bpo_pkg::coord_t x,
  input  bpo_pkg::coord_t y,
  input  bpo_pkg::coord_t z,
  input  bpo_pkg::axis_t  ax,
  input  bpo_pkg::axis_t  ay,
  input  bpo_pkg::axis_t  az,
  output logic            grp_valid,
  output bpo_pkg::proj_t  grp_lo,
  output bpo_pkg::proj_t  grp_hi
);
  import bpo_pkg::*;

  ctl_t  ctl1;
  ctl_t  ctl2;
  prod_t prod_x;
  prod_t prod_y;
  prod_t prod_z;
  sum_t  sum;
  proj_t proj;
  proj_t lo;
  proj_t hi;
  proj_t lo_next;
  proj_t hi_next;

  // Stage one: three products, one per axis component.
  always_ff @(posedge clk) begin
    prod_x <= PROD_W'(x) * PROD_W'(ax);
    prod_y <= PROD_W'(y) * PROD_W'(ay);
    prod_z <= PROD_W'(z) * PROD_W'(az);
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= in_ctl;
    end
  end

  // Stage two: dot product, then an arithmetic shift that floors.
  assign sum = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z);

  always_ff @(posedge clk) begin
    proj <= sum[SUM_W-1:FRAC_BITS];
    if (rst) begin
      ctl2 <= '0;
    end else begin
      ctl2 <= ctl1;
    end
  end

  // Stage three: running bounds; the last vertex hands the group over.
  assign lo_next = (proj < lo) ? proj : lo;
  assign hi_next = (proj > hi) ? proj : hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo        <= PROJ_MAX;
      hi        <= PROJ_MIN;
      grp_valid <= 1'b0;
    end else begin
      grp_valid <= ctl2.valid && ctl2.last;
      if (ctl2.valid) begin
        if (ctl2.last) begin
          lo <= PROJ_MAX;
          hi <= PROJ_MIN;
        end else begin
          lo <= lo_next;
          hi <= hi_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl2.valid && ctl2.last) begin
      grp_lo <= lo_next;
      grp_hi <= hi_next;
    end
  end

endmodule

FILE: hdl/bpo_merge.sv
module bpo_merge (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  bpo_pkg::proj_t first_lo,
  input  bpo_pkg::proj_t first_hi,
  input  bpo_pkg::proj_t second_lo,
  input  bpo_pkg::proj_t second_hi,
  output logic           out_valid,
  output bpo_pkg::ovl_t  overlap
);
  import bpo_pkg::*;

  logic diff_valid;
  ovl_t d1;
  ovl_t d2;

  // The two cross differences first, the smaller of them in the cycle after.
  always_ff @(posedge clk) begin
    d1 <= OVL_W'(first_hi) - OVL_W'(second_lo);
    d2 <= OVL_W'(second_hi) - OVL_W'(first_lo);
    overlap <= (d1 < d2) ? d1 : d2;
    if (rst) begin
      diff_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      diff_valid <= in_valid;
      out_valid  <= diff_valid;
    end
  end

endmodule

FILE: hdl/bpo_queue.sv
module bpo_queue #(
  parameter int DEPTH = bpo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  input  bpo_pkg::ovl_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bpo_pkg::ovl_t rd_data
);
  import bpo_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ovl_t             mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             load;
  logic             from_mem;
  logic             bypass;
  logic             push;

  // The output register refills whenever it is empty or being taken.
  assign load     = !rd_valid || rd_ready;
  assign from_mem = load && (count != '0);
  assign bypass   = load && (count == '0) && wr_valid;
  assign push     = wr_valid && !bypass;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wr_data;
    end
    if (from_mem) begin
      rd_data <= mem[head];
    end else if (bypass) begin
      rd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (load) begin
        rd_valid <= from_mem || bypass;
      end
      if (push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (from_mem) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !from_mem) begin
        count <= count + 1'b1;
      end else if (from_mem && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/bpo_checker.sv
module bpo_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [bpo_pkg::S_DATA_W-1:0] s_tdata,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [bpo_pkg::M_DATA_W-1:0] m_tdata
);
  import bpo_pkg::*;

  // A held result keeps its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A request that waits stays offered and unchanged until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("request changed while waiting");

  // Reset empties the result queue.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  // Reset frees every queue slot, so requests are taken at once.
  assert property (@(posedge clk) rst |=> s_tready)
    else $error("not ready after reset");

  // The padding above the overlap field is always zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_DATA_W-1:OVL_W] == '0)
    else $error("nonzero padding in result");

endmodule

bind box_projection_overlap_core bpo_checker u_bpo_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
